// File: rtl/ujk_pkg.sv
package ujk_pkg;

	localparam int CORDIC_STEPS  = 16;
	localparam int FRACTION_BITS = 16;
	localparam int TRIG_Q        = 30;
	localparam int TW            = 34;   // CORDIC datapath width
	localparam int TSH           = TRIG_Q - FRACTION_BITS;
	localparam int PSH           = TRIG_Q + FRACTION_BITS;
	localparam int TTSH          = 2 * TRIG_Q - FRACTION_BITS;
	localparam int NUM_GROUPS    = 11;
	localparam int GW            = 4;

	localparam logic [GW-1:0] LAST_FULL  = GW'(NUM_GROUPS - 1);
	localparam logic [GW-1:0] LAST_QUERY = GW'(1);

	localparam logic [2:0] KIND_FULL      = 3'd0;
	localparam logic [2:0] KIND_DJ_FIRST  = 3'd1;
	localparam logic [2:0] KIND_DJ_SECOND = 3'd2;
	localparam logic [2:0] KIND_DR_FIRST  = 3'd3;
	localparam logic [2:0] KIND_DR_SECOND = 3'd4;

	localparam logic signed [TW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [TW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [TW-1:0] GAIN_Q30    = 34'sd652032874;

	localparam logic [31:0] ONE_Q = 32'(1) << FRACTION_BITS;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] dq0;
		logic [31:0] dq1;
		logic [31:0] ddq0;
		logic [31:0] ddq1;
	} side_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} triple_t;

	function automatic logic signed [TW-1:0] atan_q30(input int i);
		logic signed [TW-1:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = (i < 30) ? (TW'(1) <<< (30 - i)) : '0;
		endcase
		return r;
	endfunction

	// product scaled down by 2^sh, half away from zero, then saturated
	function automatic logic [31:0] rnd_sat(input logic signed [95:0] v, input int sh);
		logic        neg;
		logic [95:0] mag;
		logic [95:0] q;
		neg = v[95];
		mag = neg ? (~v + 96'd1) : v;
		mag = mag + (96'd1 << (sh - 1));
		q   = mag >> sh;
		if (neg) begin
			if (q > 96'h8000_0000)
				q = 96'h8000_0000;
			return ~q[31:0] + 32'd1;
		end else begin
			if (q > 96'h7FFF_FFFF)
				q = 96'h7FFF_FFFF;
			return q[31:0];
		end
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return s[31:0];
	endfunction

	function automatic logic [31:0] sat_neg(input logic [31:0] a);
		return (a == 32'h8000_0000) ? 32'h7FFF_FFFF : (~a + 32'd1);
	endfunction

endpackage

// File: rtl/ujk_cordic.sv
module ujk_cordic
	import ujk_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [18:0]       angle_a,
	input  logic signed [18:0]       angle_b,
	input  side_t                    in_side,
	output logic                     out_valid,
	output logic signed [31:0]       sin_a,
	output logic signed [31:0]       cos_a,
	output logic signed [31:0]       sin_b,
	output logic signed [31:0]       cos_b,
	output side_t                    out_side
);

	logic                 v_s    [0:CORDIC_STEPS];
	side_t                side_s [0:CORDIC_STEPS];
	logic [1:0]           flip_s [0:CORDIC_STEPS];
	logic signed [TW-1:0] x_s    [0:CORDIC_STEPS][0:1];
	logic signed [TW-1:0] y_s    [0:CORDIC_STEPS][0:1];
	logic signed [TW-1:0] z_s    [0:CORDIC_STEPS][0:1];

	logic signed [18:0]   ang   [0:1];
	logic signed [TW-1:0] zw    [0:1];
	logic signed [TW-1:0] zf    [0:1];
	logic [1:0]           fl;

	assign ang[0] = angle_a;
	assign ang[1] = angle_b;

	// fold into +-pi/2; a half turn negates both results
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			zw[j] = TW'(ang[j]) <<< TSH;
			fl[j] = 1'b0;
			zf[j] = zw[j];
			if (zw[j] > HALF_PI_Q30) begin
				zf[j] = zw[j] - PI_Q30;
				fl[j] = 1'b1;
			end else if (zw[j] < -HALF_PI_Q30) begin
				zf[j] = zw[j] + PI_Q30;
				fl[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			flip_s[0] <= fl;
			for (int j = 0; j < 2; j++) begin
				x_s[0][j] <= GAIN_Q30;
				y_s[0][j] <= '0;
				z_s[0][j] <= zf[j];
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				flip_s[i+1] <= flip_s[i];
				for (int j = 0; j < 2; j++) begin
					if (!z_s[i][j][TW-1]) begin
						x_s[i+1][j] <= x_s[i][j] - (y_s[i][j] >>> i);
						y_s[i+1][j] <= y_s[i][j] + (x_s[i][j] >>> i);
						z_s[i+1][j] <= z_s[i][j] - atan_q30(i);
					end else begin
						x_s[i+1][j] <= x_s[i][j] + (y_s[i][j] >>> i);
						y_s[i+1][j] <= y_s[i][j] - (x_s[i][j] >>> i);
						z_s[i+1][j] <= z_s[i][j] + atan_q30(i);
					end
				end
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS];
	assign out_side  = side_s[CORDIC_STEPS];

	assign sin_a = 32'(flip_s[CORDIC_STEPS][0] ? -y_s[CORDIC_STEPS][0] : y_s[CORDIC_STEPS][0]);
	assign cos_a = 32'(flip_s[CORDIC_STEPS][0] ? -x_s[CORDIC_STEPS][0] : x_s[CORDIC_STEPS][0]);
	assign sin_b = 32'(flip_s[CORDIC_STEPS][1] ? -y_s[CORDIC_STEPS][1] : y_s[CORDIC_STEPS][1]);
	assign cos_b = 32'(flip_s[CORDIC_STEPS][1] ? -x_s[CORDIC_STEPS][1] : x_s[CORDIC_STEPS][1]);

endmodule

// File: rtl/universal_joint_kinematics_unit.sv
// channel   dir  handshake          payload
// s_        in   tvalid/tready      tuser kind, tdata angles, rates, accels
// m_        out  tvalid/tready      tuser group, tdata x/y/z, tlast end of run
// cfg_      in   cfg_we             cfg_wdata = reversed
//
// The first word leaves after the input word is taken, passing the fold register,
// 16 CORDIC stages, four product stages, hold register, output register.
// A full update gives 11 words on the result port, a query 2; the single
// result port is what sets the rate. Stages before it advance together and
// hold while the serialiser is full. Reset clears valids and the reversed flag.
module universal_joint_kinematics_unit
	import ujk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,   // kind
	input  logic [167:0] s_tdata,   // angle_first, angle_second, rate_first, rate_second,
	                                // accel_first, accel_second, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [3:0]   m_tuser,   // group
	output logic [95:0]  m_tdata,   // value_x, value_y, value_z
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	logic reversed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reversed_q <= 1'b0;
		end else if (cfg_we) begin
			reversed_q <= cfg_wdata;
		end
	end

	logic adv;
	side_t in_side;

	assign in_side.kind = s_tuser;
	assign in_side.dq0  = s_tdata[69:38];
	assign in_side.dq1  = s_tdata[101:70];
	assign in_side.ddq0 = s_tdata[133:102];
	assign in_side.ddq1 = s_tdata[165:134];
	assign s_tready     = adv;

	logic               cv;
	logic signed [31:0] cs0, cc0, cs1, cc1;
	side_t              cside;

	ujk_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (s_tvalid),
		.angle_a  (s_tdata[18:0]),
		.angle_b  (s_tdata[37:19]),
		.in_side  (in_side),
		.out_valid(cv),
		.sin_a    (cs0),
		.cos_a    (cc0),
		.sin_b    (cs1),
		.cos_b    (cc1),
		.out_side (cside)
	);

	// stage 1: trig results and the two-rate product
	logic               valid_s1;
	logic signed [31:0] s0_s1, c0_s1, s1_s1, c1_s1;
	logic signed [63:0] p_s1;
	side_t              side_s1;

	// stage 2: raw products
	logic               valid_s2;
	logic signed [63:0] m_s2  [0:5];
	logic signed [63:0] t_s2  [0:3];
	logic signed [63:0] ph_s2 [0:1];
	logic signed [64:0] pl_s2 [0:1];
	logic [31:0]        ts0_s2, tc0_s2, ts1_s2, tc1_s2;
	side_t              side_s2;

	// stage 3: rounded products, triple products joined
	logic               valid_s3;
	logic [31:0]        m_s3  [0:5];
	logic [31:0]        t_s3  [0:3];
	logic signed [95:0] pf_s3 [0:1];
	logic [31:0]        ts0_s3, tc0_s3, ts1_s3, tc1_s3;
	side_t              side_s3;

	// stage 4: everything at output scale
	logic               valid_s4;
	logic [31:0]        m_s4 [0:5];
	logic [31:0]        t_s4 [0:3];
	logic [31:0]        p_s4 [0:1];
	logic [31:0]        ts0_s4, tc0_s4, ts1_s4, tc1_s4;
	side_t              side_s4;
	logic               rev_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cv;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// operand selection for the rate-by-trig and rate-product multiplies
	logic signed [31:0] ma [0:5];
	logic signed [31:0] mb [0:5];
	logic signed [31:0] pb [0:1];

	always_comb begin
		if (reversed_q) begin
			ma[0] = side_s1.dq1;  mb[0] = -c0_s1;
			ma[1] = side_s1.dq1;  mb[1] = -s0_s1;
			ma[2] = side_s1.ddq1; mb[2] = -c0_s1;
			ma[3] = side_s1.ddq1; mb[3] = -s0_s1;
			ma[4] = side_s1.dq0;
			ma[5] = side_s1.dq0;
			if (side_s1.kind == KIND_FULL) begin
				mb[4] = s0_s1;  mb[5] = -c0_s1;
			end else begin
				mb[4] = c0_s1;  mb[5] = s0_s1;
			end
			pb[0] = s0_s1;  pb[1] = -c0_s1;
		end else begin
			ma[0] = side_s1.dq0;  mb[0] = c1_s1;
			ma[1] = side_s1.dq0;  mb[1] = s1_s1;
			ma[2] = side_s1.ddq0; mb[2] = c1_s1;
			ma[3] = side_s1.ddq0; mb[3] = s1_s1;
			ma[4] = side_s1.dq1;
			ma[5] = side_s1.dq1;
			if (side_s1.kind == KIND_FULL) begin
				mb[4] = -s1_s1; mb[5] = c1_s1;
			end else begin
				mb[4] = -c1_s1; mb[5] = -s1_s1;
			end
			pb[0] = -s1_s1; pb[1] = c1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s0_s1   <= cs0;
			c0_s1   <= cc0;
			s1_s1   <= cs1;
			c1_s1   <= cc1;
			p_s1    <= $signed(cside.dq0) * $signed(cside.dq1);
			side_s1 <= cside;

			for (int k = 0; k < 6; k++)
				m_s2[k] <= ma[k] * mb[k];
			t_s2[0] <= s0_s1 * s1_s1;
			t_s2[1] <= (-c0_s1) * s1_s1;
			t_s2[2] <= (-s0_s1) * c1_s1;
			t_s2[3] <= c0_s1 * c1_s1;
			for (int k = 0; k < 2; k++) begin
				ph_s2[k] <= $signed(p_s1[63:32]) * pb[k];
				pl_s2[k] <= $signed({1'b0, p_s1[31:0]}) * pb[k];
			end
			ts0_s2  <= rnd_sat(96'(s0_s1), TSH);
			tc0_s2  <= rnd_sat(96'(c0_s1), TSH);
			ts1_s2  <= rnd_sat(96'(s1_s1), TSH);
			tc1_s2  <= rnd_sat(96'(c1_s1), TSH);
			side_s2 <= side_s1;

			for (int k = 0; k < 6; k++)
				m_s3[k] <= rnd_sat(96'(m_s2[k]), TRIG_Q);
			for (int k = 0; k < 4; k++)
				t_s3[k] <= rnd_sat(96'(t_s2[k]), TTSH);
			for (int k = 0; k < 2; k++)
				pf_s3[k] <= $signed({ph_s2[k], 32'd0}) + 96'(pl_s2[k]);
			ts0_s3  <= ts0_s2;
			tc0_s3  <= tc0_s2;
			ts1_s3  <= ts1_s2;
			tc1_s3  <= tc1_s2;
			side_s3 <= side_s2;

			m_s4    <= m_s3;
			t_s4    <= t_s3;
			for (int k = 0; k < 2; k++)
				p_s4[k] <= rnd_sat(pf_s3[k], PSH);
			ts0_s4  <= ts0_s3;
			tc0_s4  <= tc0_s3;
			ts1_s4  <= ts1_s3;
			tc1_s4  <= tc1_s3;
			side_s4 <= side_s3;
			rev_s4  <= reversed_q;
		end
	end

	// result words of one item
	triple_t     grp [0:NUM_GROUPS-1];
	logic [GW-1:0] grp_last;

	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++)
			grp[g] = '0;
		if (side_s4.kind == KIND_FULL) begin
			grp_last = LAST_FULL;
			if (rev_s4) begin
				grp[0] = '{x: tc1_s4, y: '0, z: ts1_s4};
				grp[1] = '{x: t_s4[0], y: tc0_s4, z: t_s4[2]};
				grp[2] = '{x: t_s4[1], y: ts0_s4, z: t_s4[3]};
				grp[3] = '{x: sat_neg(side_s4.dq0), y: m_s4[0], z: m_s4[1]};
				grp[4] = '{x: '0, y: p_s4[0], z: p_s4[1]};
				grp[5] = '{x: sat_neg(side_s4.ddq0), y: m_s4[2], z: m_s4[3]};
				grp[7] = '{x: -ONE_Q, y: '0, z: '0};
				grp[8] = '{x: '0, y: -tc0_s4, z: -ts0_s4};
				grp[10] = '{x: '0, y: m_s4[4], z: m_s4[5]};
			end else begin
				grp[0] = '{x: tc1_s4, y: t_s4[0], z: t_s4[1]};
				grp[1] = '{x: '0, y: tc0_s4, z: ts0_s4};
				grp[2] = '{x: ts1_s4, y: t_s4[2], z: t_s4[3]};
				grp[3] = '{x: m_s4[0], y: side_s4.dq1, z: m_s4[1]};
				grp[4] = '{x: p_s4[0], y: '0, z: p_s4[1]};
				grp[5] = '{x: m_s4[2], y: side_s4.ddq1, z: m_s4[3]};
				grp[7] = '{x: tc1_s4, y: '0, z: ts1_s4};
				grp[8] = '{x: '0, y: ONE_Q, z: '0};
				grp[9] = '{x: m_s4[4], y: '0, z: m_s4[5]};
			end
			grp[6] = '{x: sat_add(grp[4].x, grp[5].x),
			           y: sat_add(grp[4].y, grp[5].y),
			           z: sat_add(grp[4].z, grp[5].z)};
		end else begin
			grp_last = LAST_QUERY;
			if (rev_s4) begin
				if (side_s4.kind == KIND_DJ_FIRST)
					grp[1] = '{x: '0, y: ts0_s4, z: -tc0_s4};
				else if (side_s4.kind == KIND_DR_FIRST)
					grp[1] = '{x: '0, y: m_s4[4], z: m_s4[5]};
			end else begin
				if (side_s4.kind == KIND_DJ_SECOND)
					grp[0] = '{x: -ts1_s4, y: '0, z: tc1_s4};
				else if (side_s4.kind == KIND_DR_SECOND)
					grp[0] = '{x: m_s4[4], y: '0, z: m_s4[5]};
			end
		end
	end

	// serialiser
	triple_t       hold_q [0:NUM_GROUPS-1];
	logic [GW-1:0] last_q;
	logic [GW-1:0] cnt_q;
	logic          busy_q;
	logic          out_valid_q;
	logic          out_last_q;
	logic [GW-1:0] out_grp_q;
	triple_t       out_q;

	logic out_free, emit, fin, take;

	assign out_free = !out_valid_q || m_tready;
	assign emit     = busy_q && out_free;
	assign fin      = emit && (cnt_q == last_q);
	assign take     = valid_s4 && (!busy_q || fin);
	assign adv      = !valid_s4 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				cnt_q <= cnt_q + GW'(1);
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_q <= grp;
			last_q <= grp_last;
		end
		if (emit) begin
			out_q      <= hold_q[cnt_q];
			out_grp_q  <= cnt_q;
			out_last_q <= fin;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_grp_q;
	assign m_tdata  = {out_q.z, out_q.y, out_q.x};
	assign m_tlast  = out_last_q;

	ast_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= last_q)
		else $error("word counter ran past end of run");

	ast_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (last_q == LAST_FULL || last_q == LAST_QUERY))
		else $error("bad run length");

	ast_last_grp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tuser == LAST_FULL || m_tuser == LAST_QUERY))
		else $error("tlast on wrong word");

	ast_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !take |=> valid_s4)
		else $error("stalled item dropped");

	ast_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		take && busy_q |-> fin)
		else $error("serialiser overwritten mid run");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ujk_pkg::*;

	typedef struct {
		logic [2:0]         kind;
		logic signed [18:0] ang0, ang1;
		logic signed [31:0] rate0, rate1, acc0, acc1;
	} joint_cmd_t;

	typedef struct {
		logic [3:0]  grp;
		logic [31:0] x, y, z;
		logic        lst;
	} joint_group_t;

	localparam logic [2:0] KIND_UNKNOWN = 3'd5;   // 5..7 are undefined requests
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [2:0]   s_tuser = '0;
	logic [167:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [3:0]   m_tuser;
	logic [95:0]  m_tdata;
	logic         m_tlast;
	logic         cfg_we = 1'b0;
	logic         cfg_wdata = 1'b0;

	joint_cmd_t   pending_cmds[$];
	joint_group_t expected_groups[$];
	logic         pred_reversed = 1'b0;
	logic         idle_on = 1'b1;
	int           cmds_taken = 0;
	int           groups_seen = 0;
	int           mismatches = 0;
	int           quiet_cycles = 0;
	int           send_gap = 0;
	int           recv_stall = 0;
	int           hold_left = 0;
	bit           hold_done = 0;

	longint atan_q30_tab[30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149,
		1048576, 524288, 262144, 131072, 65536,
		32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
	};

	universal_joint_kinematics_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// a*b / 2^sh, half away from zero, saturated
	function automatic longint scale_mul(longint a, longint b, int sh);
		logic signed [127:0] pr;
		logic [127:0]        mag;
		logic                neg;
		longint              lim;
		pr  = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		neg = (a < 0) != (b < 0);
		mag = pr[127] ? -pr : pr;
		mag = (mag + (128'd1 << (sh - 1))) >> sh;
		lim = neg ? 64'sd2147483648 : 64'sd2147483647;
		if (mag > 128'(lim))
			mag = 128'(lim);
		return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	task automatic joint_sincos(input longint ang, output longint s, output longint c);
		longint z, x, y, nx, pi_q, half_pi;
		bit     flip;
		pi_q    = PI_Q30;
		half_pi = HALF_PI_Q30;
		z = ang * (64'sd1 << (TRIG_Q - FRACTION_BITS));
		x = GAIN_Q30;
		y = 0;
		flip = 0;
		if (z > half_pi) begin
			z -= pi_q; flip = 1;
		end else if (z < -half_pi) begin
			z += pi_q; flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q30_tab[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += atan_q30_tab[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	task automatic push_group(int k, longint x, longint y, longint z, bit lst);
		joint_group_t g;
		g.grp = 4'(k);
		g.x = 32'(clamp32(x));
		g.y = 32'(clamp32(y));
		g.z = 32'(clamp32(z));
		g.lst = lst;
		expected_groups = {expected_groups, g};
	endtask

	task automatic predict_kinematics(input joint_cmd_t c);
		longint s0, c0, s1, c1, ts0, tc0, ts1, tc1, p, one, dq0, dq1, ddq0, ddq1;
		longint v[3], d[3], a[3];
		joint_sincos(c.ang0, s0, c0);
		joint_sincos(c.ang1, s1, c1);
		ts0 = scale_mul(s0, 1, TSH); tc0 = scale_mul(c0, 1, TSH);
		ts1 = scale_mul(s1, 1, TSH); tc1 = scale_mul(c1, 1, TSH);
		dq0 = c.rate0; dq1 = c.rate1; ddq0 = c.acc0; ddq1 = c.acc1;
		p = dq0 * dq1;
		one = 64'sd1 << FRACTION_BITS;
		if (c.kind == KIND_FULL) begin
			if (pred_reversed) begin
				push_group(0, tc1, 0, ts1, 0);
				push_group(1, scale_mul(s0, s1, TTSH), tc0, scale_mul(-s0, c1, TTSH), 0);
				push_group(2, scale_mul(-c0, s1, TTSH), ts0, scale_mul(c0, c1, TTSH), 0);
				v = '{clamp32(-dq0), scale_mul(dq1, -c0, TRIG_Q), scale_mul(dq1, -s0, TRIG_Q)};
				d = '{0, scale_mul(p, s0, PSH), scale_mul(p, -c0, PSH)};
				a = '{clamp32(-ddq0), scale_mul(ddq1, -c0, TRIG_Q),
					scale_mul(ddq1, -s0, TRIG_Q)};
			end else begin
				push_group(0, tc1, scale_mul(s0, s1, TTSH), scale_mul(-c0, s1, TTSH), 0);
				push_group(1, 0, tc0, ts0, 0);
				push_group(2, ts1, scale_mul(-s0, c1, TTSH), scale_mul(c0, c1, TTSH), 0);
				v = '{scale_mul(dq0, c1, TRIG_Q), dq1, scale_mul(dq0, s1, TRIG_Q)};
				d = '{scale_mul(p, -s1, PSH), 0, scale_mul(p, c1, PSH)};
				a = '{scale_mul(ddq0, c1, TRIG_Q), ddq1, scale_mul(ddq0, s1, TRIG_Q)};
			end
			push_group(3, v[0], v[1], v[2], 0);
			push_group(4, d[0], d[1], d[2], 0);
			push_group(5, a[0], a[1], a[2], 0);
			push_group(6, a[0] + d[0], a[1] + d[1], a[2] + d[2], 0);
			if (pred_reversed) begin
				push_group(7, -one, 0, 0, 0);
				push_group(8, 0, -tc0, -ts0, 0);
				push_group(9, 0, 0, 0, 0);
				push_group(10, 0, scale_mul(dq0, s0, TRIG_Q), scale_mul(dq0, -c0, TRIG_Q), 1);
			end else begin
				push_group(7, tc1, 0, ts1, 0);
				push_group(8, 0, one, 0, 0);
				push_group(9, scale_mul(dq1, -s1, TRIG_Q), 0, scale_mul(dq1, c1, TRIG_Q), 0);
				push_group(10, 0, 0, 0, 1);
			end
		end else begin
			v = '{0, 0, 0};
			d = '{0, 0, 0};
			if (pred_reversed) begin
				if (c.kind == KIND_DJ_FIRST)
					d = '{0, ts0, -tc0};
				else if (c.kind == KIND_DR_FIRST)
					d = '{0, scale_mul(dq0, c0, TRIG_Q), scale_mul(dq0, s0, TRIG_Q)};
			end else begin
				if (c.kind == KIND_DJ_SECOND)
					v = '{-ts1, 0, tc1};
				else if (c.kind == KIND_DR_SECOND)
					v = '{scale_mul(dq1, -c1, TRIG_Q), 0, scale_mul(dq1, -s1, TRIG_Q)};
			end
			push_group(0, v[0], v[1], v[2], 0);
			push_group(1, d[0], d[1], d[2], 1);
		end
	endtask

	// sender
	always @(posedge clk) begin
		logic nv;
		if (s_tvalid && s_tready) begin
			predict_kinematics(pending_cmds[0]);
			void'(pending_cmds.pop_front());
			cmds_taken++;
		end
		nv = 1'b0;
		if (s_tvalid && !s_tready) begin
			nv = 1'b1;
		end else if (send_gap > 0) begin
			send_gap--;
		end else if (pending_cmds.size() > 0) begin
			nv = 1'b1;
			s_tuser <= pending_cmds[0].kind;
			s_tdata <= {2'b00, pending_cmds[0].acc1, pending_cmds[0].acc0,
				pending_cmds[0].rate1, pending_cmds[0].rate0,
				pending_cmds[0].ang1, pending_cmds[0].ang0};
			if (idle_on && $urandom_range(0, 12) == 0)
				send_gap = $urandom_range(1, 10);
		end
		s_tvalid <= nv;
	end

	// receiver and checker
	always @(posedge clk) begin
		joint_group_t g;
		logic         rdy;
		if (m_tvalid && m_tready) begin
			groups_seen++;
			if (expected_groups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: group %0d x %h y %h z %h last %b",
						m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tlast);
			end else begin
				g = expected_groups.pop_front();
				if (m_tuser !== g.grp || m_tdata[31:0] !== g.x || m_tdata[63:32] !== g.y
						|| m_tdata[95:64] !== g.z || m_tlast !== g.lst) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp grp %0d %h %h %h last %b, got grp %0d %h %h %h last %b",
							g.grp, g.x, g.y, g.z, g.lst, m_tuser,
							m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tlast);
				end
			end
		end
		// one long hold-off to back the pipe up into the input
		if (!hold_done && cmds_taken >= 60) begin
			hold_done = 1;
			hold_left = 400;
		end
		rdy = 1'b0;
		if (hold_left > 0)
			hold_left--;
		else if (recv_stall > 0)
			recv_stall--;
		else begin
			rdy = 1'b1;
			if (idle_on && $urandom_range(0, 10) == 0)
				recv_stall = $urandom_range(1, 10);
		end
		m_tready <= rdy;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no words moved for %0d cycles", WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic add_cmd(logic [2:0] k, int a0, int a1, int r0, int r1, int x0, int x1);
		joint_cmd_t c;
		c.kind = k;
		c.ang0 = 19'(a0); c.ang1 = 19'(a1);
		c.rate0 = r0; c.rate1 = r1; c.acc0 = x0; c.acc1 = x1;
		pending_cmds = {pending_cmds, c};
	endtask

	function automatic int rand_angle();
		return int'($urandom_range(0, 411774)) - 205887;
	endfunction

	function automatic int rand_rate();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			1, 2: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return int'($urandom());
		endcase
	endfunction

	task automatic add_random(int n);
		logic [2:0] k;
		repeat (n) begin
			if ($urandom_range(0, 9) < 5)
				k = KIND_FULL;
			else if ($urandom_range(0, 9) == 0)
				k = 3'($urandom_range(KIND_UNKNOWN, 7));
			else
				k = 3'($urandom_range(KIND_DJ_FIRST, KIND_DR_SECOND));
			add_cmd(k, rand_angle(), rand_angle(), rand_rate(), rand_rate(),
				rand_rate(), rand_rate());
		end
	endtask

	task automatic add_directed();
		for (int k = 0; k < 8; k++)
			add_cmd(3'(k), 30000, -70000, 123456, -654321, 99999, -11111);
		add_cmd(KIND_FULL, 205887, -205887, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7FFF_FFFF);
		add_cmd(KIND_FULL, -205887, 205887, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000);
		add_cmd(KIND_FULL, 0, 0, 0, 0, 0, 0);
		// either side of the quarter-turn fold
		add_cmd(KIND_FULL, 102943, 102944, 65536, 65536, -65536, 65536);
		add_cmd(KIND_FULL, -102944, -102943, -1, 1, 1, -1);
		add_cmd(KIND_DR_FIRST, 205887, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
		add_cmd(KIND_DR_SECOND, 0, -205887, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
		add_cmd(KIND_DJ_FIRST, -102944, 102944, 0, 0, 0, 0);
		add_cmd(KIND_DJ_SECOND, 102944, -102944, 0, 0, 0, 0);
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_groups.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reversed(logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		pred_reversed = val;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_reversed(1'b0);
		add_directed();
		add_random(130);
		wait_drained();
		write_reversed(1'b1);
		add_directed();
		add_random(130);
		wait_drained();
		write_reversed(1'b0);
		idle_on = 1'b0;
		add_random(110);
		wait_drained();
		$display("covered %0d requests over normal and reversed forms, %0d result words checked",
			cmds_taken, groups_seen);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
